FILE: design/arc_band_outline_generator_top_macros.svh
// Assertion macros for the arc band outline generator
`ifndef ARC_BAND_OUTLINE_GENERATOR_TOP_MACROS_SVH
`define ARC_BAND_OUTLINE_GENERATOR_TOP_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ABOG_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Check a next-cycle implication outside reset
`define ABOG_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

FILE: design/abog_pkg.sv
`timescale 1ns / 1ps
package abog_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int SINE_BITS       = 16;

    localparam logic [2:0] CMD_MOVE      = 3'd0;
    localparam logic [2:0] CMD_LINE      = 3'd1;
    localparam logic [2:0] CMD_ARC_CW_S  = 3'd2;
    localparam logic [2:0] CMD_ARC_CW_L  = 3'd3;
    localparam logic [2:0] CMD_ARC_CCW_S = 3'd4;
    localparam logic [2:0] CMD_ARC_CCW_L = 3'd5;
    localparam logic [2:0] CMD_END       = 3'd6;

    localparam logic [1:0] ST_DRAWN    = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_CULLED   = 2'd2;

    localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
    localparam logic [2:0] REG_CLIP_TOP    = 3'd1;
    localparam logic [2:0] REG_CLIP_RIGHT  = 3'd2;
    localparam logic [2:0] REG_CLIP_BOTTOM = 3'd3;
    localparam logic [2:0] REG_OPA_FLOOR   = 3'd4;

    localparam int PT_W  = 22;
    localparam int RAD_W = 20;

    // Work packet handed from the front end to the back end
    typedef struct packed {
        logic [1:0]  kind;       // ST_DRAWN, ST_REJECTED or ST_CULLED
        logic        full_turn;
        logic        rounded;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [15:0] r;
        logic [15:0] w;
        logic [8:0]  st;         // reduced to 0..359
        logic [8:0]  en;
    } job_t;

    typedef struct packed {
        logic [2:0]  command;
        logic signed [PT_W-1:0] point_col;
        logic signed [PT_W-1:0] point_row;
        logic [RAD_W-1:0] arc_radius;
        logic [1:0]  status;
        logic        last_item;
    } result_t;

    // sin(d deg) in Q.SINE_BITS, d = 0..90, as the Taylor series gives it
    function automatic logic [SINE_BITS:0] sine_entry(input logic [6:0] d);
        logic [63:0] x, sum, term;
        logic [63:0] v;
        x = (64'(d > 7'd90 ? 7'd90 : d) * 64'd3373259426) / 64'd180;
        sum = x;
        term = x;
        for (int k = 1; k <= 10; k++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) != 0) sum = sum - term;
            else sum = sum + term;
        end
        v = (sum + (64'd1 << (29 - SINE_BITS))) >> (30 - SINE_BITS);
        if (v > (64'd1 << SINE_BITS)) v = 64'd1 << SINE_BITS;
        return v[SINE_BITS:0];
    endfunction

    typedef logic [SINE_BITS:0] sine_rom_t [0:90];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t t;
        for (int i = 0; i <= 90; i++) t[i] = sine_entry(7'(i));
        return t;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: design/abog_front.sv
`timescale 1ns / 1ps
module abog_front (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [15:0] centre_col,
    input  logic [15:0] centre_row,
    input  logic [15:0] circle_radius,
    input  logic [15:0] band_width,
    input  logic [9:0]  start_deg,
    input  logic [9:0]  end_deg,
    input  logic        round_caps,
    input  logic [7:0]  opacity,
    input  logic        has_pattern,
    input  logic        mask_on,
    input  logic signed [15:0] clip_left,
    input  logic signed [15:0] clip_top,
    input  logic signed [15:0] clip_right,
    input  logic signed [15:0] clip_bottom,
    input  logic [7:0]  opacity_floor,
    output logic        job_valid,
    input  logic        job_ready,
    output abog_pkg::job_t job
);
    import abog_pkg::*;

    // Stage 1 registers: raw request, reject flag, box tests
    logic        s1_valid_reg;
    job_t        s1_job_reg;
    logic        s1_rej_reg, s1_box_vis_reg, s1_box_cull_reg;
    logic signed [17:0] s1_dx1_reg, s1_dx2_reg, s1_dy1_reg, s1_dy2_reg;
    logic [16:0] s1_small_reg;
    // Stage 2 registers: squares
    logic        s2_valid_reg;
    job_t        s2_job_reg;
    logic        s2_rej_reg, s2_box_vis_reg, s2_box_cull_reg, s2_small_pos_reg;
    logic [35:0] s2_x1_reg, s2_x2_reg, s2_y1_reg, s2_y2_reg, s2_s2_reg;
    // Stage 3 output register
    logic        out_valid_reg;
    job_t        out_job_reg;

    logic adv1, adv2, adv3;
    assign adv3 = !out_valid_reg || job_ready;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    logic signed [17:0] cx18, cy18, r18, lo_x, hi_x, lo_y, hi_y;
    logic signed [17:0] cl, ct, cr, cb;
    logic [15:0] w_cl;
    logic rej;
    always_comb
    begin
        cx18 = 18'(signed'(centre_col));
        cy18 = 18'(signed'(centre_row));
        r18  = signed'({2'b00, circle_radius});
        lo_x = cx18 - r18;
        hi_x = cx18 + r18;
        lo_y = cy18 - r18;
        hi_y = cy18 + r18;
        cl = 18'(clip_left);
        ct = 18'(clip_top);
        cr = 18'(clip_right);
        cb = 18'(clip_bottom);
        w_cl = (band_width > circle_radius) ? circle_radius : band_width;
        rej = (opacity <= opacity_floor) || (band_width == 16'd0)
            || (start_deg == end_deg) || has_pattern || mask_on;
    end

    function automatic logic [8:0] mod360(input logic [9:0] a);
        logic [10:0] t;
        t = {1'b0, a};
        if (t >= 11'd720) t = t - 11'd720;
        else if (t >= 11'd360) t = t - 11'd360;
        return t[8:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_valid_reg <= in_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
            if (adv3) out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_job_reg.kind      <= ST_DRAWN;
            s1_job_reg.full_turn <= ({1'b0, start_deg} + 11'd360 == {1'b0, end_deg})
                                 || ({1'b0, end_deg} + 11'd360 == {1'b0, start_deg});
            s1_job_reg.rounded   <= round_caps;
            s1_job_reg.cx        <= signed'(centre_col);
            s1_job_reg.cy        <= signed'(centre_row);
            s1_job_reg.r         <= circle_radius;
            s1_job_reg.w         <= w_cl;
            s1_job_reg.st        <= mod360(start_deg);
            s1_job_reg.en        <= mod360(end_deg);
            s1_rej_reg           <= rej;
            s1_box_vis_reg  <= (cl <= lo_x) && (ct <= lo_y) && (cr >= hi_x) && (cb >= hi_y);
            s1_box_cull_reg <= ((cl < lo_x) && (cr < lo_x)) || ((cl > hi_x) && (cr > hi_x))
                            || ((ct < lo_y) && (cb < lo_y)) || ((ct > hi_y) && (cb > hi_y));
            s1_dx1_reg <= cx18 - cl;
            s1_dx2_reg <= cx18 - cr;
            s1_dy1_reg <= cy18 - ct;
            s1_dy2_reg <= cy18 - cb;
            s1_small_reg <= {1'b0, circle_radius} - {1'b0, w_cl};
        end
        if (adv2)
        begin
            s2_job_reg       <= s1_job_reg;
            s2_rej_reg       <= s1_rej_reg;
            s2_box_vis_reg   <= s1_box_vis_reg;
            s2_box_cull_reg  <= s1_box_cull_reg;
            s2_small_pos_reg <= s1_small_reg != 17'd0;
            s2_x1_reg <= 36'(s1_dx1_reg * s1_dx1_reg);
            s2_x2_reg <= 36'(s1_dx2_reg * s1_dx2_reg);
            s2_y1_reg <= 36'(s1_dy1_reg * s1_dy1_reg);
            s2_y2_reg <= 36'(s1_dy2_reg * s1_dy2_reg);
            s2_s2_reg <= 36'(s1_small_reg * s1_small_reg);
        end
        if (adv3)
        begin
            out_job_reg <= s2_job_reg;
            if (s2_rej_reg) out_job_reg.kind <= ST_REJECTED;
            else if (!s2_box_vis_reg && (s2_box_cull_reg || (s2_small_pos_reg
                     && ({1'b0, s2_x1_reg} + {1'b0, s2_y1_reg} < {1'b0, s2_s2_reg})
                     && ({1'b0, s2_x1_reg} + {1'b0, s2_y2_reg} < {1'b0, s2_s2_reg})
                     && ({1'b0, s2_x2_reg} + {1'b0, s2_y1_reg} < {1'b0, s2_s2_reg})
                     && ({1'b0, s2_x2_reg} + {1'b0, s2_y2_reg} < {1'b0, s2_s2_reg}))))
                out_job_reg.kind <= ST_CULLED;
            else out_job_reg.kind <= ST_DRAWN;
        end
    end

    assign job_valid = out_valid_reg;
    assign job       = out_job_reg;
endmodule

FILE: design/abog_fifo.sv
`timescale 1ns / 1ps
module abog_fifo (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  abog_pkg::job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output abog_pkg::job_t rd_data
);
    import abog_pkg::*;

    job_t       mem_reg [0:3];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic do_wr, do_rd;

    assign wr_ready = cnt_reg != 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (do_wr) wp_reg <= wp_reg + 2'd1;
            if (do_rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(do_wr) - 3'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule

FILE: design/abog_back.sv
`timescale 1ns / 1ps
module abog_back (
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_ready,
    input  abog_pkg::job_t job,
    output logic out_valid,
    input  logic out_ready,
    output abog_pkg::result_t result
);
    import abog_pkg::*;

    localparam int SH = SINE_BITS - COORD_FRAC_BITS;

    // Sequencer: step 0..5 of a band, band 0/1 of a full turn
    logic [2:0] step_reg;
    logic       band_reg;

    logic [8:0] st, en;
    logic       rnd, last_band;
    logic [8:0] span;
    logic       big_span;
    logic       pt_outer, pt_end;
    logic       single;
    always_comb
    begin
        if (job.full_turn)
        begin
            st  = band_reg ? 9'd180 : 9'd0;
            en  = band_reg ? 9'd0 : 9'd180;
            rnd = 1'b0;
            last_band = band_reg;
        end
        else
        begin
            st  = job.st;
            en  = job.en;
            rnd = job.rounded;
            last_band = 1'b1;
        end
        span  = (st > en) ? 9'd360 - st + en : en - st;
        big_span = span >= 9'd180;
        single = job.kind != ST_DRAWN;
        // step 0 and 4 use outer(start); 1 outer(end); 2 inner(end); 3 inner(start)
        pt_outer = (step_reg == 3'd0) || (step_reg == 3'd1) || (step_reg == 3'd4);
        pt_end   = (step_reg == 3'd1) || (step_reg == 3'd2);
    end

    // Stage A: sine lookup for the point this step needs
    logic [8:0]  ang;
    logic [6:0]  m;
    logic [1:0]  q;
    always_comb
    begin
        ang = pt_end ? en : st;
        if (ang >= 9'd270)      begin q = 2'd3; m = 7'(ang - 9'd270); end
        else if (ang >= 9'd180) begin q = 2'd2; m = 7'(ang - 9'd180); end
        else if (ang >= 9'd90)  begin q = 2'd1; m = 7'(ang - 9'd90); end
        else                    begin q = 2'd0; m = 7'(ang); end
    end

    logic take;
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic adv_a, adv_b, adv_c;
    assign adv_c = !c_valid_reg || out_ready;
    assign adv_b = !b_valid_reg || adv_c;
    assign adv_a = !a_valid_reg || adv_b;
    assign take  = job_valid && adv_a;

    logic done_job;
    assign done_job = single || ((step_reg == 3'd5) && last_band);
    assign job_ready = adv_a && done_job;

    typedef struct packed {
        logic [2:0]  command;
        logic [RAD_W-1:0] rad;
        logic [1:0]  status;
        logic        last;
        logic        zero_pt;
        logic [1:0]  q;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
    } ctl_t;

    ctl_t        a_ctl_reg, b_ctl_reg;
    logic [15:0] a_r_reg;
    logic [SINE_BITS:0] a_s_reg, a_c_reg;
    logic [SH+16:0] b_os_reg, b_oc_reg;

    ctl_t ctl;
    logic [15:0] pr;
    logic [20:0] rq, iq, capq;
    logic [15:0] ir;
    always_comb
    begin
        ir   = job.r - job.w;
        rq   = 21'({job.r, 4'd0} >> (4 - COORD_FRAC_BITS));
        iq   = 21'({ir, 4'd0} >> (4 - COORD_FRAC_BITS));
        capq = rnd ? 21'(({5'd0, job.w} << COORD_FRAC_BITS) + 21'd1) >> 1 : 21'd0;
        pr   = pt_outer ? job.r : ir;
        ctl.status = job.kind;
        ctl.q  = q;
        ctl.cx = job.cx;
        ctl.cy = job.cy;
        ctl.zero_pt = 1'b0;
        ctl.last = 1'b0;
        ctl.rad = '0;
        ctl.command = CMD_END;
        if (single)
        begin
            ctl.zero_pt = 1'b1;
            ctl.last = 1'b1;
        end
        else
        begin
            case (step_reg)
                3'd0: ctl.command = CMD_MOVE;
                3'd1:
                begin
                    ctl.command = big_span ? CMD_ARC_CW_L : CMD_ARC_CW_S;
                    ctl.rad = (rq > 21'(2**RAD_W - 1)) ? '1 : RAD_W'(rq);
                end
                3'd2, 3'd4:
                begin
                    ctl.command = rnd ? CMD_ARC_CW_L : CMD_LINE;
                    ctl.rad = (capq > 21'(2**RAD_W - 1)) ? '1 : RAD_W'(capq);
                end
                3'd3:
                begin
                    ctl.command = big_span ? CMD_ARC_CCW_L : CMD_ARC_CCW_S;
                    ctl.rad = (iq > 21'(2**RAD_W - 1)) ? '1 : RAD_W'(iq);
                end
                default:
                begin
                    ctl.command = CMD_END;
                    ctl.zero_pt = 1'b1;
                    ctl.last = last_band;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            band_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a) a_valid_reg <= job_valid;
            if (adv_b) b_valid_reg <= a_valid_reg;
            if (adv_c) c_valid_reg <= b_valid_reg;
            if (take)
            begin
                if (done_job)
                begin
                    step_reg <= 3'd0;
                    band_reg <= 1'b0;
                end
                else if (step_reg == 3'd5)
                begin
                    step_reg <= 3'd0;
                    band_reg <= 1'b1;
                end
                else step_reg <= step_reg + 3'd1;
            end
        end
    end

    logic signed [PT_W+2:0] bx, by, x, y;
    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_ctl_reg <= ctl;
            a_r_reg   <= pr;
            a_s_reg   <= SINE_ROM[m];
            a_c_reg   <= SINE_ROM[7'd90 - m];
        end
        if (adv_b)
        begin
            b_ctl_reg <= a_ctl_reg;
            // full 34-bit product before rounding down to Q.COORD_FRAC_BITS
            b_os_reg  <= (SH+17)'((34'(a_r_reg) * 34'(a_s_reg) + 34'(1 << (SH - 1))) >> SH);
            b_oc_reg  <= (SH+17)'((34'(a_r_reg) * 34'(a_c_reg) + 34'(1 << (SH - 1))) >> SH);
        end
        if (adv_c)
        begin
            result.command    <= b_ctl_reg.command;
            result.arc_radius <= b_ctl_reg.rad;
            result.status     <= b_ctl_reg.status;
            result.last_item  <= b_ctl_reg.last;
            if (b_ctl_reg.zero_pt)
            begin
                result.point_col <= '0;
                result.point_row <= '0;
            end
            else
            begin
                result.point_col <= x > (PT_W+3)'(2**(PT_W-1) - 1) ? {1'b0, {(PT_W-1){1'b1}}}
                                  : x < -(PT_W+3)'(2**(PT_W-1)) ? {1'b1, {(PT_W-1){1'b0}}}
                                  : PT_W'(x);
                result.point_row <= y > (PT_W+3)'(2**(PT_W-1) - 1) ? {1'b0, {(PT_W-1){1'b1}}}
                                  : y < -(PT_W+3)'(2**(PT_W-1)) ? {1'b1, {(PT_W-1){1'b0}}}
                                  : PT_W'(y);
            end
        end
    end

    logic signed [PT_W+2:0] os, oc;
    always_comb
    begin
        bx = (PT_W+3)'(b_ctl_reg.cx) <<< COORD_FRAC_BITS;
        by = (PT_W+3)'(b_ctl_reg.cy) <<< COORD_FRAC_BITS;
        os = signed'((PT_W+3)'(b_os_reg));
        oc = signed'((PT_W+3)'(b_oc_reg));
        case (b_ctl_reg.q)
            2'd0:    begin x = bx + oc; y = by + os; end
            2'd1:    begin x = bx - os; y = by + oc; end
            2'd2:    begin x = bx - oc; y = by - os; end
            default: begin x = bx + os; y = by - oc; end
        endcase
    end

    assign out_valid = c_valid_reg;
endmodule

FILE: design/arc_band_outline_generator_top.sv
`timescale 1ns / 1ps
// Channel     | Direction | Beat contents
// s_axis      | in        | one arc request
// m_axis      | out       | one path command; tlast marks the final beat of a request
// cfg         | in        | register write, index 0..4
//
// Each drawn request gives six beats (twelve for a full turn), one beat per cycle while
// m_axis_tready stays high; the back-end sequencer sets that rate. Rejected and culled
// requests give one beat. A request passes three front stages, the queue and three back
// stages before its first beat is valid. The front end keeps taking requests while the
// back end is busy, until the four-entry queue fills. Reset clears all control state.
module arc_band_outline_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] centre_col, [31:16] centre_row, [47:32] circle_radius,
    // [63:48] band_width, [73:64] start_deg, [83:74] end_deg, [84] round_caps,
    // [92:85] opacity, [93] has_pattern, [94] mask_on, [95] zero
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] command, [24:3] point_col, [46:25] point_row, [66:47] arc_radius,
    // [68:67] status, [71:69] zero
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import abog_pkg::*;

    logic signed [15:0] clip_left_reg, clip_top_reg, clip_right_reg, clip_bottom_reg;
    logic [7:0] opa_floor_reg;

    // Hold the clip rectangle and opacity floor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= 16'sd0;
            clip_top_reg    <= 16'sd0;
            clip_right_reg  <= 16'sd32767;
            clip_bottom_reg <= 16'sd32767;
            opa_floor_reg   <= 8'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLIP_LEFT:   clip_left_reg   <= signed'(cfg_data);
                REG_CLIP_TOP:    clip_top_reg    <= signed'(cfg_data);
                REG_CLIP_RIGHT:  clip_right_reg  <= signed'(cfg_data);
                REG_CLIP_BOTTOM: clip_bottom_reg <= signed'(cfg_data);
                REG_OPA_FLOOR:   opa_floor_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic f_valid, f_ready, q_valid, q_ready;
    job_t f_job, q_job;
    result_t res;

    abog_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .centre_col(s_axis_tdata[15:0]), .centre_row(s_axis_tdata[31:16]),
        .circle_radius(s_axis_tdata[47:32]), .band_width(s_axis_tdata[63:48]),
        .start_deg(s_axis_tdata[73:64]), .end_deg(s_axis_tdata[83:74]),
        .round_caps(s_axis_tdata[84]), .opacity(s_axis_tdata[92:85]),
        .has_pattern(s_axis_tdata[93]), .mask_on(s_axis_tdata[94]),
        .clip_left(clip_left_reg), .clip_top(clip_top_reg),
        .clip_right(clip_right_reg), .clip_bottom(clip_bottom_reg),
        .opacity_floor(opa_floor_reg),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    abog_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    abog_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .result(res)
    );

    assign m_axis_tdata = {3'd0, res.status, res.arc_radius, res.point_row,
                           res.point_col, res.command};
    assign m_axis_tlast = res.last_item;
endmodule

FILE: design/abog_checker.sv
`timescale 1ns / 1ps
`include "arc_band_outline_generator_top_macros.svh"
module abog_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import abog_pkg::*;

    // A beat that is not drawn is a lone end command
    `ABOG_ASSERT_IMP(a_single_end, clk, rst_n, m_axis_tvalid && m_axis_tdata[68:67] != ST_DRAWN, m_axis_tdata[2:0] == CMD_END && m_axis_tlast, "non-drawn beat must be a final end")
    // The final beat is always an end command
    `ABOG_ASSERT_IMP(a_last_end, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[2:0] == CMD_END, "last beat must be end")
    // A stalled beat holds its payload
    `ABOG_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")
endmodule

bind arc_band_outline_generator_top abog_checker u_abog_checker (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
